/* rtl/segment_plane_intersection_top_macros.svh */
// ----------------------------------------------------------------------------
// segment plane intersection assertion macros
// shared concurrent check forms, clocked on clk and quiet during reset
// ----------------------------------------------------------------------------
`ifndef SEGMENT_PLANE_INTERSECTION_TOP_MACROS_SVH
`define SEGMENT_PLANE_INTERSECTION_TOP_MACROS_SVH

// property must hold at every sampled edge
`define SPI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen
`define SPI_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* rtl/spi_pkg.sv */
// ----------------------------------------------------------------------------
// spi_pkg
// widths, codes and shared types of the segment plane intersection pipeline
// ----------------------------------------------------------------------------
package spi_pkg;

    localparam int COORD_W   = 32;              // q16.16 coordinate
    localparam int DIFF_W    = COORD_W + 1;     // end - start, start - point
    localparam int PROD_W    = COORD_W + DIFF_W; // one dot product term
    localparam int SUM_W     = PROD_W + 2;      // sum of three terms
    localparam int MAG_W     = PROD_W;          // |den| and normalized num
    localparam int Q_W       = COORD_W;         // rounded |d|*t
    localparam int X_W       = Q_W + MAG_W;     // dividend |d|*num + den/2
    localparam int DIV_STEPS = Q_W;             // one quotient bit a stage
    localparam int SAT_W     = COORD_W + 2;     // hit sum and box bounds
    localparam int NUM_CFG   = 8;
    localparam int CFG_IDX_W = $clog2(NUM_CFG);
    // register stages from accept to the result strobe
    localparam int PIPE_STAGES = DIV_STEPS + 10;

    localparam logic [SUM_W-1:0]          PARALLEL_EPS = SUM_W'(4295);
    localparam logic signed [COORD_W-1:0] Q16_ONE      = 32'sh0001_0000;
    localparam logic signed [COORD_W-1:0] EXTENT_OFF   = -Q16_ONE;

    typedef enum logic [1:0] {
        ST_PARALLEL    = 2'd0,
        ST_OFF_SEGMENT = 2'd1,
        ST_OUTSIDE     = 2'd2,
        ST_HIT         = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POINT_X  = 3'd0,
        CFG_POINT_Y  = 3'd1,
        CFG_POINT_Z  = 3'd2,
        CFG_NORMAL_X = 3'd3,
        CFG_NORMAL_Y = 3'd4,
        CFG_NORMAL_Z = 3'd5,
        CFG_EXTENT_X = 3'd6,
        CFG_EXTENT_Y = 3'd7
    } cfg_idx_t;

    // per beat data that rides alongside the dividers
    typedef struct packed {
        logic                       parallel;
        logic                       off_seg;
        logic [2:0]                 d_neg;
        logic [2:0][COORD_W-1:0]    start;
    } side_t;

endpackage

/* rtl/spi_divider.sv */
// ----------------------------------------------------------------------------
// spi_divider
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module spi_divider (
    input  logic                      clk,
    input  logic [spi_pkg::X_W-1:0]   dividend,
    input  logic [spi_pkg::MAG_W-1:0] divisor,
    output logic [spi_pkg::Q_W-1:0]   quotient
);
    import spi_pkg::*;

    // dividend < divisor * 2^Q_W, so the upper part starts below the divisor
    logic [MAG_W-1:0] rem_reg [DIV_STEPS-1];
    logic [Q_W-1:0]   lo_reg  [DIV_STEPS-1];
    logic [MAG_W-1:0] den_reg [DIV_STEPS-1];
    logic [Q_W-1:0]   q_reg   [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [MAG_W-1:0] rem_src;
        logic [MAG_W-1:0] den_src;
        logic [Q_W-1:0]   lo_src;
        logic [Q_W-1:0]   q_src;
        logic [MAG_W:0]   trial;
        logic [MAG_W:0]   diff;
        logic             fits;

        if (k == 0) begin : g_first
            assign rem_src = dividend[X_W-1:Q_W];
            assign lo_src  = dividend[Q_W-1:0];
            assign den_src = divisor;
            assign q_src   = '0;
        end else begin : g_later
            assign rem_src = rem_reg[k-1];
            assign lo_src  = lo_reg[k-1];
            assign den_src = den_reg[k-1];
            assign q_src   = q_reg[k-1];
        end

        assign trial = {rem_src, lo_src[Q_W-1]};
        assign diff  = trial - {1'b0, den_src};
        assign fits  = (trial >= {1'b0, den_src});

        always_ff @(posedge clk)
        begin
            q_reg[k] <= {q_src[Q_W-2:0], fits};
        end

        if (k < DIV_STEPS - 1) begin : g_carry
            always_ff @(posedge clk)
            begin
                rem_reg[k] <= fits ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
                lo_reg[k]  <= {lo_src[Q_W-2:0], 1'b0};
                den_reg[k] <= den_src;
            end
        end
    end

    assign quotient = q_reg[DIV_STEPS-1];

endmodule

/* rtl/segment_plane_intersection_top.sv */
// ----------------------------------------------------------------------------
// segment_plane_intersection_top
// segment against bounded plane, q16.16 in, exact q32.32 dot products
// done and the result beat are registered together in the last of the
// PIPE_STAGES register stages after the accept
// throughput: one segment beat per clock, busy stays low
// latency is set mostly by the 32 stage divider, one quotient bit per stage per lane
// reset clears the valid chain and loads the register defaults
// the receiver cannot stall, each result beat shows for one cycle only
// ----------------------------------------------------------------------------
`include "segment_plane_intersection_top_macros.svh"

module segment_plane_intersection_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [spi_pkg::COORD_W-1:0] start_x,
    input  logic signed [spi_pkg::COORD_W-1:0] start_y,
    input  logic signed [spi_pkg::COORD_W-1:0] start_z,
    input  logic signed [spi_pkg::COORD_W-1:0] end_x,
    input  logic signed [spi_pkg::COORD_W-1:0] end_y,
    input  logic signed [spi_pkg::COORD_W-1:0] end_z,
    input  logic                              cfg_we,
    input  logic [spi_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [spi_pkg::COORD_W-1:0]       cfg_data,
    output logic                              done,
    output spi_pkg::status_t                  status,
    output logic signed [spi_pkg::COORD_W-1:0] hit_x,
    output logic signed [spi_pkg::COORD_W-1:0] hit_y,
    output logic signed [spi_pkg::COORD_W-1:0] hit_z
);
    import spi_pkg::*;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] cfg_reg [NUM_CFG];
    logic signed [COORD_W-1:0] pnt [3];
    logic signed [COORD_W-1:0] nrm [3];
    logic                      area_off;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < NUM_CFG; i++) begin
                cfg_reg[i] <= '0;
            end
            cfg_reg[CFG_NORMAL_Z] <= Q16_ONE;
            cfg_reg[CFG_EXTENT_X] <= EXTENT_OFF;
            cfg_reg[CFG_EXTENT_Y] <= EXTENT_OFF;
        end else if (cfg_we) begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    assign pnt[0] = cfg_reg[CFG_POINT_X];
    assign pnt[1] = cfg_reg[CFG_POINT_Y];
    assign pnt[2] = cfg_reg[CFG_POINT_Z];
    assign nrm[0] = cfg_reg[CFG_NORMAL_X];
    assign nrm[1] = cfg_reg[CFG_NORMAL_Y];
    assign nrm[2] = cfg_reg[CFG_NORMAL_Z];
    // either extent at exactly -1.0 turns the box test off
    assign area_off = (cfg_reg[CFG_EXTENT_X] == EXTENT_OFF)
                   || (cfg_reg[CFG_EXTENT_Y] == EXTENT_OFF);

    // ------------------------------------------------------------------
    // valid chain, one bit per register stage
    // ------------------------------------------------------------------
    logic                   accept;
    logic [PIPE_STAGES-1:0] vld_reg;

    // fully pipelined: a beat is taken every cycle
    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[PIPE_STAGES-2:0], accept};
        end
    end

    assign done = vld_reg[PIPE_STAGES-1];

    // ------------------------------------------------------------------
    // stage 0: capture the segment
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] s0_reg [3];
    logic signed [COORD_W-1:0] e0_reg [3];

    always_ff @(posedge clk)
    begin
        if (accept) begin
            s0_reg[0] <= start_x;
            s0_reg[1] <= start_y;
            s0_reg[2] <= start_z;
            e0_reg[0] <= end_x;
            e0_reg[1] <= end_y;
            e0_reg[2] <= end_z;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: d = end - start, w = start - point
    // ------------------------------------------------------------------
    logic signed [DIFF_W-1:0]  d1_reg [3];
    logic signed [DIFF_W-1:0]  w1_reg [3];
    logic signed [COORD_W-1:0] s1_reg [3];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++) begin
            d1_reg[i] <= {e0_reg[i][COORD_W-1], e0_reg[i]}
                       - {s0_reg[i][COORD_W-1], s0_reg[i]};
            w1_reg[i] <= {s0_reg[i][COORD_W-1], s0_reg[i]}
                       - {pnt[i][COORD_W-1], pnt[i]};
            s1_reg[i] <= s0_reg[i];
        end
    end

    // ------------------------------------------------------------------
    // stage 2: the six dot product terms, exact q32.32
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0]  pd2_reg [3];
    logic signed [PROD_W-1:0]  pw2_reg [3];
    logic signed [DIFF_W-1:0]  d2_reg  [3];
    logic signed [COORD_W-1:0] s2_reg  [3];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++) begin
            pd2_reg[i] <= nrm[i] * d1_reg[i];
            pw2_reg[i] <= nrm[i] * w1_reg[i];
            d2_reg[i]  <= d1_reg[i];
            s2_reg[i]  <= s1_reg[i];
        end
    end

    // ------------------------------------------------------------------
    // stage 3: den = n.d, wsum = n.w
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0]   den3_reg;
    logic signed [SUM_W-1:0]   wsum3_reg;
    logic signed [DIFF_W-1:0]  d3_reg [3];
    logic signed [COORD_W-1:0] s3_reg [3];

    always_ff @(posedge clk)
    begin
        den3_reg  <= SUM_W'(pd2_reg[0]) + SUM_W'(pd2_reg[1]) + SUM_W'(pd2_reg[2]);
        wsum3_reg <= SUM_W'(pw2_reg[0]) + SUM_W'(pw2_reg[1]) + SUM_W'(pw2_reg[2]);
        for (int i = 0; i < 3; i++) begin
            d3_reg[i] <= d2_reg[i];
            s3_reg[i] <= s2_reg[i];
        end
    end

    // ------------------------------------------------------------------
    // stage 4: flip den to non-negative and flip num along with it, num starts as -wsum
    // ------------------------------------------------------------------
    logic [SUM_W-1:0]          den4_reg;
    logic signed [SUM_W-1:0]   num4_reg;
    logic signed [DIFF_W-1:0]  d4_reg [3];
    logic signed [COORD_W-1:0] s4_reg [3];

    always_ff @(posedge clk)
    begin
        if (den3_reg[SUM_W-1]) begin
            den4_reg <= -den3_reg;
            num4_reg <= wsum3_reg;
        end else begin
            den4_reg <= den3_reg;
            num4_reg <= -wsum3_reg;
        end
        for (int i = 0; i < 3; i++) begin
            d4_reg[i] <= d3_reg[i];
            s4_reg[i] <= s3_reg[i];
        end
    end

    // ------------------------------------------------------------------
    // stage 5: parallel and off segment tests, |d| per lane
    // ------------------------------------------------------------------
    side_t               side5_reg;
    side_t               side5_next;
    logic [MAG_W-1:0]    num5_reg;
    logic [MAG_W-1:0]    den5_reg;
    logic [Q_W-1:0]      dmag5_reg [3];
    logic [DIFF_W-1:0]   dneg4     [3];

    always_comb
    begin
        side5_next.parallel = (den4_reg < PARALLEL_EPS);
        // t < 0 or t > 1
        side5_next.off_seg  = num4_reg[SUM_W-1] || (den4_reg < $unsigned(num4_reg));
        for (int i = 0; i < 3; i++) begin
            dneg4[i]               = -d4_reg[i];
            side5_next.d_neg[i]    = d4_reg[i][DIFF_W-1];
            side5_next.start[i]    = s4_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        side5_reg <= side5_next;
        num5_reg  <= num4_reg[MAG_W-1:0];
        den5_reg  <= den4_reg[MAG_W-1:0];
        for (int i = 0; i < 3; i++) begin
            dmag5_reg[i] <= d4_reg[i][DIFF_W-1] ? dneg4[i][Q_W-1:0] : d4_reg[i][Q_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // stage 6: |d| * num as two partial products
    // ------------------------------------------------------------------
    side_t                    side6_reg;
    logic [MAG_W-1:0]         den6_reg;
    logic [2*Q_W-1:0]         pl6_reg [3];
    logic [MAG_W-1:0]         ph6_reg [3];

    always_ff @(posedge clk)
    begin
        side6_reg <= side5_reg;
        den6_reg  <= den5_reg;
        for (int i = 0; i < 3; i++) begin
            pl6_reg[i] <= dmag5_reg[i] * num5_reg[Q_W-1:0];
            ph6_reg[i] <= dmag5_reg[i] * num5_reg[MAG_W-1:Q_W];
        end
    end

    // ------------------------------------------------------------------
    // stage 7: dividend with the rounding half of den folded in
    // ------------------------------------------------------------------
    side_t            side7_reg;
    logic [MAG_W-1:0] den7_reg;
    logic [X_W-1:0]   x7_reg [3];

    always_ff @(posedge clk)
    begin
        side7_reg <= side6_reg;
        den7_reg  <= den6_reg;
        for (int i = 0; i < 3; i++) begin
            x7_reg[i] <= X_W'(pl6_reg[i]) + {ph6_reg[i], {Q_W{1'b0}}}
                       + X_W'(den6_reg >> 1);
        end
    end

    // ------------------------------------------------------------------
    // divider lanes, round(|d| * num / den)
    // ------------------------------------------------------------------
    logic [Q_W-1:0] quo [3];
    side_t          side_reg [DIV_STEPS];

    for (genvar g = 0; g < 3; g++) begin : g_lane
        spi_divider u_div (
            .clk      (clk),
            .dividend (x7_reg[g]),
            .divisor  (den7_reg),
            .quotient (quo[g])
        );
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= side7_reg;
        for (int k = 1; k < DIV_STEPS; k++) begin
            side_reg[k] <= side_reg[k-1];
        end
    end

    // ------------------------------------------------------------------
    // stage 40: hit = start +/- q, clamped to 32 bits
    // ------------------------------------------------------------------
    side_t                     side40_reg;
    logic signed [COORD_W-1:0] h40_reg  [3];
    logic signed [COORD_W-1:0] h40_next [3];
    logic signed [SAT_W-1:0]   hsum     [3];
    side_t                     side_out;

    assign side_out = side_reg[DIV_STEPS-1];

    always_comb
    begin
        for (int i = 0; i < 3; i++) begin
            if (side_out.d_neg[i]) begin
                hsum[i] = {{2{side_out.start[i][COORD_W-1]}}, side_out.start[i]}
                        - {2'b00, quo[i]};
            end else begin
                hsum[i] = {{2{side_out.start[i][COORD_W-1]}}, side_out.start[i]}
                        + {2'b00, quo[i]};
            end
            // top three bits disagree means the sum left the 32 bit range
            if (hsum[i][SAT_W-1:COORD_W-1] != {3{hsum[i][SAT_W-1]}}) begin
                h40_next[i] = hsum[i][SAT_W-1] ? {1'b1, {(COORD_W-1){1'b0}}}
                                               : {1'b0, {(COORD_W-1){1'b1}}};
            end else begin
                h40_next[i] = hsum[i][COORD_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        side40_reg <= side_out;
        for (int i = 0; i < 3; i++) begin
            h40_reg[i] <= h40_next[i];
        end
    end

    // ------------------------------------------------------------------
    // stage 41: box test and result beat
    // ------------------------------------------------------------------
    logic signed [SAT_W-1:0] box_lo [2];
    logic signed [SAT_W-1:0] box_hi [2];
    logic signed [SAT_W-1:0] h_ext  [2];
    logic [1:0]              in_box;
    status_t                 status_next;
    status_t                 status_reg;
    logic signed [COORD_W-1:0] hit_reg [3];

    always_comb
    begin
        for (int i = 0; i < 2; i++) begin
            box_lo[i] = {{2{pnt[i][COORD_W-1]}}, pnt[i]}
                      - {{2{cfg_reg[CFG_EXTENT_X + i][COORD_W-1]}}, cfg_reg[CFG_EXTENT_X + i]};
            box_hi[i] = {{2{pnt[i][COORD_W-1]}}, pnt[i]}
                      + {{2{cfg_reg[CFG_EXTENT_X + i][COORD_W-1]}}, cfg_reg[CFG_EXTENT_X + i]};
            h_ext[i]  = {{2{h40_reg[i][COORD_W-1]}}, h40_reg[i]};
            in_box[i] = (box_lo[i] < h_ext[i]) && (h_ext[i] < box_hi[i]);
        end
        priority if (side40_reg.parallel) begin
            status_next = ST_PARALLEL;
        end else if (side40_reg.off_seg) begin
            status_next = ST_OFF_SEGMENT;
        end else if (!area_off && !(in_box[0] && in_box[1])) begin
            status_next = ST_OUTSIDE;
        end else begin
            status_next = ST_HIT;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        for (int i = 0; i < 3; i++) begin
            // no point to report when parallel or off the segment
            hit_reg[i] <= (side40_reg.parallel || side40_reg.off_seg) ? '0 : h40_reg[i];
        end
    end

    assign status = status_reg;
    assign hit_x  = hit_reg[0];
    assign hit_y  = hit_reg[1];
    assign hit_z  = hit_reg[2];

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `SPI_ASSERT(a_fixed_latency, accept |-> ##(PIPE_STAGES) done, "result beat missing")
    `SPI_ASSERT(a_miss_zero, done && (status == ST_PARALLEL || status == ST_OFF_SEGMENT) |-> hit_x == 0 && hit_y == 0 && hit_z == 0, "miss carries a point")
    `SPI_NEVER(a_box_off, done && area_off && status == ST_OUTSIDE, "box test ran while disabled")

endmodule

/* test/tb_segment_plane_intersection_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segment_plane_intersection_top
// checks segment against bounded plane results for several plane and box
// settings, with directed corner segments, then random crossing segments
// mixed with raw random and degenerate ones, with and without random start gaps
// ----------------------------------------------------------------------------
module tb_segment_plane_intersection_top;
    import spi_pkg::*;

    // result of one segment as the block should report it
    typedef struct {
        status_t             st;
        logic signed [31:0]  x;
        logic signed [31:0]  y;
        logic signed [31:0]  z;
    } crossing_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [31:0] start_x, start_y, start_z, end_x, end_y, end_z;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0] cfg_data;
    logic done;
    status_t status;
    logic signed [31:0] hit_x, hit_y, hit_z;

    // local copy of the plane registers, index order of the block
    logic signed [31:0] plane_regs [NUM_CFG];

    crossing_t pending_crossings [$];
    int mismatches;
    int beats_sent;
    int results_seen;
    int hits_seen;
    bit idle_enable;

    segment_plane_intersection_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .start_x(start_x), .start_y(start_y), .start_z(start_z),
        .end_x(end_x), .end_y(end_y), .end_z(end_z),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .status(status),
        .hit_x(hit_x), .hit_y(hit_y), .hit_z(hit_z)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // generous ceiling, normal run is well under a tenth of this
    initial
    begin
        #5ms;
        $display("[segment_plane_intersection_top] ERROR");
        $finish;
    end

    // exact intersection in wide signed math, rounded half away from zero
    function automatic crossing_t predict_crossing(logic signed [31:0] sx,
        logic signed [31:0] sy, logic signed [31:0] sz, logic signed [31:0] ex,
        logic signed [31:0] ey, logic signed [31:0] ez);
        logic signed [127:0] d [3];
        logic signed [127:0] s [3];
        logic signed [127:0] h [3];
        logic signed [127:0] den, num, mag, q;
        logic signed [63:0] px, py, bx, by;
        crossing_t r;
        d[0] = ex - sx;
        d[1] = ey - sy;
        d[2] = ez - sz;
        s[0] = sx;
        s[1] = sy;
        s[2] = sz;
        r.st = ST_HIT;
        r.x = '0;
        r.y = '0;
        r.z = '0;
        den = plane_regs[CFG_NORMAL_X] * d[0] + plane_regs[CFG_NORMAL_Y] * d[1]
            + plane_regs[CFG_NORMAL_Z] * d[2];
        num = -(plane_regs[CFG_NORMAL_X] * (s[0] - plane_regs[CFG_POINT_X])
              + plane_regs[CFG_NORMAL_Y] * (s[1] - plane_regs[CFG_POINT_Y])
              + plane_regs[CFG_NORMAL_Z] * (s[2] - plane_regs[CFG_POINT_Z]));
        if ((den < 0 ? -den : den) < 128'sd4295)
        begin
            r.st = ST_PARALLEL;
            return r;
        end
        if (den < 0)
        begin
            den = -den;
            num = -num;
        end
        if (num < 0 || num > den)
        begin
            r.st = ST_OFF_SEGMENT;
            return r;
        end
        for (int i = 0; i < 3; i++)
        begin
            mag = d[i] < 0 ? -d[i] : d[i];
            q = (mag * num + den / 2) / den;
            h[i] = d[i] < 0 ? s[i] - q : s[i] + q;
            if (h[i] > 128'sd2147483647)
                h[i] = 128'sd2147483647;
            if (h[i] < -128'sd2147483648)
                h[i] = -128'sd2147483648;
        end
        r.x = h[0][31:0];
        r.y = h[1][31:0];
        r.z = h[2][31:0];
        if (plane_regs[CFG_EXTENT_X] != EXTENT_OFF && plane_regs[CFG_EXTENT_Y] != EXTENT_OFF)
        begin
            px = plane_regs[CFG_POINT_X];
            py = plane_regs[CFG_POINT_Y];
            bx = plane_regs[CFG_EXTENT_X];
            by = plane_regs[CFG_EXTENT_Y];
            if (!(px - bx < h[0] && h[0] < px + bx && py - by < h[1] && h[1] < py + by))
                r.st = ST_OUTSIDE;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        $display("mismatch %0d: %s got %h want %h", results_seen, what, got, want);
    endtask

    // result checker, done is a one cycle strobe that cannot be held off
    always @(posedge clk)
    begin
        crossing_t want;
        if (rst_n && done)
        begin
            results_seen++;
            if (pending_crossings.size() == 0)
                report_mismatch("unexpected beat", {30'd0, status}, '0);
            else
            begin
                want = pending_crossings.pop_front();
                if (status != want.st)
                    report_mismatch("status", {30'd0, status}, {30'd0, want.st});
                if (hit_x != want.x)
                    report_mismatch("hit_x", hit_x, want.x);
                if (hit_y != want.y)
                    report_mismatch("hit_y", hit_y, want.y);
                if (hit_z != want.z)
                    report_mismatch("hit_z", hit_z, want.z);
                if (want.st == ST_HIT)
                    hits_seen++;
            end
        end
    end

    // one segment beat, held until the block takes it, then maybe a gap
    task automatic send_segment(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
        logic [31:0] ex, logic [31:0] ey, logic [31:0] ez);
        start <= 1'b1;
        start_x <= sx;
        start_y <= sy;
        start_z <= sz;
        end_x <= ex;
        end_y <= ey;
        end_z <= ez;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_crossings.push_back(predict_crossing(sx, sy, sz, ex, ey, ez));
        beats_sent++;
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 14))
                @(posedge clk);
        end
    endtask

    // drain the pipe, then let the latency pass before touching registers
    task automatic wait_idle();
        start <= 1'b0;
        while (pending_crossings.size() != 0)
            @(posedge clk);
        repeat (PIPE_STAGES + 8)
            @(posedge clk);
    endtask

    // load all eight plane registers, block is idle here
    task automatic load_plane(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
        logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
        logic [31:0] bx, logic [31:0] by);
        logic [31:0] vals [NUM_CFG];
        vals = '{px, py, pz, nx, ny, nz, bx, by};
        wait_idle();
        for (int i = 0; i < NUM_CFG; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data <= vals[i];
            plane_regs[i] = vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_extent();
        unique case ($urandom_range(0, 5))
            0: return EXTENT_OFF;
            1: return 32'sh7fff_ffff;
            2: return '0;
            3: return -$urandom_range(1, 65535);   // empty box, not the sentinel
            default: return $urandom_range(1, 32'h0080_0000);
        endcase
    endfunction

    // random segment: mostly one that crosses the plane near its point
    task automatic send_random_segment();
        logic [31:0] sx, sy, sz, ex, ey, ez;
        int mode;
        mode = $urandom_range(0, 9);
        sx = $urandom;
        sy = $urandom;
        sz = $urandom;
        ex = $urandom;
        ey = $urandom;
        ez = $urandom;
        if (mode < 6)
        begin
            sx = plane_regs[CFG_POINT_X] + $signed($urandom_range(0, 32'h0040_0000)) - 32'sh20_0000;
            sy = plane_regs[CFG_POINT_Y] + $signed($urandom_range(0, 32'h0040_0000)) - 32'sh20_0000;
            ex = plane_regs[CFG_POINT_X] + $signed($urandom_range(0, 32'h0040_0000)) - 32'sh20_0000;
            ey = plane_regs[CFG_POINT_Y] + $signed($urandom_range(0, 32'h0040_0000)) - 32'sh20_0000;
            sz = plane_regs[CFG_POINT_Z] + $urandom_range(0, 32'h0010_0000);
            ez = plane_regs[CFG_POINT_Z] - $urandom_range(0, 32'h0010_0000);
            if ($urandom_range(0, 1))
            begin
                sz = ez;
                ez = plane_regs[CFG_POINT_Z] + $urandom_range(0, 32'h0010_0000);
            end
        end
        else if (mode == 6)
        begin
            // zero length segment is always parallel
            ex = sx;
            ey = sy;
            ez = sz;
        end
        else if (mode == 7)
        begin
            // starts exactly on the plane point
            sx = plane_regs[CFG_POINT_X];
            sy = plane_regs[CFG_POINT_Y];
            sz = plane_regs[CFG_POINT_Z];
        end
        send_segment(sx, sy, sz, ex, ey, ez);
    endtask

    // reset values: z plane through origin, area check off
    task automatic test_reset_defaults();
        send_segment(0, 0, 32'sh1_0000, 0, 0, -32'sh1_0000);
        send_segment(32'sh3_0000, -32'sh2_0000, -32'sh5_0000, 32'sh1_0000, 32'sh7_0000,
            32'sh5_0000);
        send_segment(0, 0, 32'sh1_0000, 0, 0, 32'sh2_0000);
        send_segment(5, 6, 7, 5, 6, 7);
    endtask

    // corner segments: extreme fields, ends on the plane, parallel, off segment
    task automatic test_directed();
        load_plane(0, 0, 0, 0, 0, 32'sh1_0000, 32'sh4_0000, 32'sh4_0000);
        send_segment(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
            32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_segment(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
            32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        send_segment(0, 0, 0, 32'sh1_0000, 0, 32'sh1_0000);          // t = 0
        send_segment(32'sh1_0000, 0, 32'sh1_0000, 0, 0, 0);          // t = 1
        send_segment(0, 0, 32'sh1_0000, 32'sh1_0000, 0, 32'sh1_0000); // parallel
        send_segment(0, 0, 32'sh1_0000, 0, 0, 32'sh0_8000);          // misses
        send_segment(32'sh4_0000, 0, 32'sh1_0000, 32'sh4_0000, 0, -32'sh1_0000); // box edge
        send_segment(32'sh3_ffff, 32'sh3_ffff, 1, -32'sh3_ffff, 32'sh3_ffff, -1);
        send_segment(1, 2, 3, 4, 5, -6);                             // odd rounding
        // tiny denominator just under, at and just over the parallel limit
        load_plane(0, 0, 0, 0, 0, 1, EXTENT_OFF, 32'sh1_0000);
        send_segment(0, 0, 0, 0, 0, 4294);
        send_segment(0, 0, -1, 0, 0, 4294);
        send_segment(0, 0, -1, 0, 0, 4295);
        // zero normal
        load_plane(32'h7fff_ffff, 32'h8000_0000, 5, 0, 0, 0, 0, 0);
        send_segment(0, 0, 0, 32'sh1_0000, 32'sh1_0000, 32'sh1_0000);
        // extreme normal and point
        load_plane(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
            32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_segment(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_segment(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
            32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        // negative box that is not the off value
        load_plane(0, 0, 0, 0, 0, 32'sh1_0000, -32'sh2, 32'sh1_0000);
        send_segment(0, 0, 32'sh1_0000, 0, 0, -32'sh1_0000);
    endtask

    // random plane settings, each followed by a burst of random segments
    task automatic test_config_sweep(int phases, int per_phase);
        for (int p = 0; p < phases; p++)
        begin
            if (p % 4 == 0)
                load_plane($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    pick_extent(), pick_extent());
            else
                load_plane($signed($urandom_range(0, 32'h0040_0000)) - 32'sh20_0000,
                    $signed($urandom_range(0, 32'h0040_0000)) - 32'sh20_0000,
                    $signed($urandom_range(0, 32'h0040_0000)) - 32'sh20_0000,
                    $signed($urandom_range(0, 32'h0004_0000)) - 32'sh2_0000,
                    $signed($urandom_range(0, 32'h0004_0000)) - 32'sh2_0000,
                    $urandom_range(32'sh1_0000, 32'sh8_0000),
                    pick_extent(), pick_extent());
            repeat (per_phase)
                send_random_segment();
        end
    endtask

    // back to back beats, no gaps within each burst of segments
    task automatic test_streaming();
        idle_enable = 1'b0;
        test_config_sweep(4, 100);
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        start_x = '0;
        start_y = '0;
        start_z = '0;
        end_x = '0;
        end_y = '0;
        end_z = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatches = 0;
        beats_sent = 0;
        results_seen = 0;
        hits_seen = 0;
        idle_enable = 1'b1;
        plane_regs = '{0, 0, 0, 0, 0, 32'sh1_0000, EXTENT_OFF, EXTENT_OFF};
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_directed();
        test_config_sweep(26, 50);
        test_streaming();

        wait_idle();
        $display("sent %0d segments, checked %0d results, %0d inside hits",
            beats_sent, results_seen, hits_seen);
        $display("covered reset defaults, corner segments and 30+ plane settings");
        if (mismatches == 0)
            $display("[segment_plane_intersection_top] OK");
        else
            $display("[segment_plane_intersection_top] ERROR");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/spi_pkg.sv
rtl/spi_divider.sv
rtl/segment_plane_intersection_top.sv
test/tb_segment_plane_intersection_top.sv
